// ----- sv/rrq_pkg.sv -----
// Shared types and constants of the round-robin ready queue.
`default_nettype none

package rrq_pkg;

    localparam int ID_W        = 3;
    localparam int ID_COUNT    = 8;
    localparam int REGS_W      = 24;
    localparam int OUT_ADDR_W  = 21;
    localparam int COUNT_OUT_W = 4;
    localparam int FIFO_DEPTH  = 2;

    typedef enum logic [1:0] {
        ACT_LOAD     = 2'd0,
        ACT_UNLOAD   = 2'd1,
        ACT_EXPIRE   = 2'd2,
        ACT_DISPATCH = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ERR_OK       = 3'd0,
        ERR_LOADED   = 3'd1,
        ERR_ABSENT   = 3'd2,
        ERR_FULL     = 3'd3,
        ERR_EMPTY    = 3'd4,
        ERR_RESERVED = 3'd5
    } err_t;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_UNLOAD,
        OP_EXPIRE,
        OP_DISPATCH,
        OP_REJECT
    } op_t;

    typedef enum logic [1:0] {
        TS_UNLOADED = 2'd0,
        TS_FRESH    = 2'd1,
        TS_RUNNING  = 2'd2
    } tstate_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_EXEC,
        BK_SCAN_RD,
        BK_SCAN_CHK,
        BK_HEAD_RD,
        BK_HEAD_WAIT,
        BK_DONE
    } back_state_t;

    typedef struct packed {
        op_t               op;
        logic [ID_W-1:0]   id;
        logic [REGS_W-1:0] regs;
    } cmd_t;

endpackage

`default_nettype wire

// ----- sv/round_robin_ready_queue.sv -----
// Top level of the round-robin ready queue task scheduler.
//
//   channel | ports        | moves
//   --------+--------------+------------------------------------------------
//   input   | s_valid/ready| action, process id and preempted context
//   result  | m_valid/ready| error, head, dispatch context, loaded count
//
// Items pass a front register and a two-entry command queue. Load, reject, dispatch
// and every error go from execute to done; an expiry rereads the head; an unload
// reads each queued entry, shifts those past the match toward the head and rereads
// the head unless it empties the queue. The back starts an item only once the
// previous result has been taken; the front keeps accepting until the command
// queue fills. Reset is synchronous and clears the queue count and all task states.
`default_nettype none

module round_robin_ready_queue
    import rrq_pkg::*;
#(
    parameter int MAX_TASKS    = 8,
    parameter int ADDRESS_BITS = 21
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [1:0]             s_action,
    input  wire logic [ID_W-1:0]        s_process_id,
    input  wire logic [OUT_ADDR_W-1:0]  s_saved_address,
    input  wire logic [7:0]             s_saved_wreg,
    input  wire logic [7:0]             s_saved_status,
    input  wire logic [7:0]             s_saved_bank,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [2:0]                  m_error,
    output logic                        m_head_valid,
    output logic [ID_W-1:0]             m_head_process,
    output logic                        m_fresh_start,
    output logic [OUT_ADDR_W-1:0]       m_resume_address,
    output logic [7:0]                  m_resume_wreg,
    output logic [7:0]                  m_resume_status,
    output logic [7:0]                  m_resume_bank,
    output logic [COUNT_OUT_W-1:0]      m_loaded_count
);

    localparam int CMD_W = $bits(cmd_t) + ADDRESS_BITS;

    logic                    push_valid;
    logic                    push_ready;
    cmd_t                    push_cmd;
    logic [ADDRESS_BITS-1:0] push_addr;
    logic                    pop_valid;
    logic                    pop;
    logic [CMD_W-1:0]        pop_data;
    cmd_t                    pop_cmd;
    logic [ADDRESS_BITS-1:0] pop_addr;

    assign pop_cmd  = cmd_t'(pop_data[CMD_W-1:ADDRESS_BITS]);
    assign pop_addr = pop_data[ADDRESS_BITS-1:0];

    rrq_front #(
        .MAX_TASKS    (MAX_TASKS),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_process_id    (s_process_id),
        .s_saved_address (s_saved_address),
        .s_saved_wreg    (s_saved_wreg),
        .s_saved_status  (s_saved_status),
        .s_saved_bank    (s_saved_bank),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_cmd        (push_cmd),
        .push_addr       (push_addr)
    );

    rrq_cmd_fifo #(
        .WIDTH (CMD_W)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_cmd, push_addr}),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_data   (pop_data)
    );

    rrq_back #(
        .MAX_TASKS    (MAX_TASKS),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd_valid        (pop_valid),
        .cmd_pop          (pop),
        .cmd              (pop_cmd),
        .cmd_addr         (pop_addr),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_error          (m_error),
        .m_head_valid     (m_head_valid),
        .m_head_process   (m_head_process),
        .m_fresh_start    (m_fresh_start),
        .m_resume_address (m_resume_address),
        .m_resume_wreg    (m_resume_wreg),
        .m_resume_status  (m_resume_status),
        .m_resume_bank    (m_resume_bank),
        .m_loaded_count   (m_loaded_count)
    );

endmodule

`default_nettype wire

// ----- sv/rrq_front.sv -----
// Input stage: accepts items and classifies them into scheduler commands.
`default_nettype none

module rrq_front
    import rrq_pkg::*;
#(
    parameter int MAX_TASKS    = 8,
    parameter int ADDRESS_BITS = 21
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [1:0]              s_action,
    input  wire logic [ID_W-1:0]         s_process_id,
    input  wire logic [OUT_ADDR_W-1:0]   s_saved_address,
    input  wire logic [7:0]              s_saved_wreg,
    input  wire logic [7:0]              s_saved_status,
    input  wire logic [7:0]              s_saved_bank,
    output logic                         push_valid,
    input  wire logic                    push_ready,
    output cmd_t                         push_cmd,
    output logic [ADDRESS_BITS-1:0]      push_addr
);

    localparam int COPY_W = (ADDRESS_BITS < OUT_ADDR_W) ? ADDRESS_BITS : OUT_ADDR_W;

    logic                    hold_valid_reg;
    logic                    hold_valid_next;
    cmd_t                    cmd_reg;
    cmd_t                    cmd_next;
    logic [ADDRESS_BITS-1:0] addr_reg;
    logic [ADDRESS_BITS-1:0] addr_next;
    logic                    accept;
    logic                    reserved;

    assign s_ready    = !hold_valid_reg || push_ready;
    assign accept     = s_valid && s_ready;
    assign push_valid = hold_valid_reg;
    assign push_cmd   = cmd_reg;
    assign push_addr  = addr_reg;

    always_comb begin
        hold_valid_next = accept || (hold_valid_reg && !push_ready);
        reserved = (s_process_id == '0) || (int'(s_process_id) >= MAX_TASKS);

        cmd_next      = cmd_reg;
        addr_next     = addr_reg;
        if (accept) begin
            cmd_next.id   = s_process_id;
            cmd_next.regs = {s_saved_bank, s_saved_status, s_saved_wreg};
            addr_next     = '0;
            addr_next[COPY_W-1:0] = s_saved_address[COPY_W-1:0];
            unique case (action_t'(s_action))
                ACT_LOAD:     cmd_next.op = reserved ? OP_REJECT : OP_LOAD;
                ACT_UNLOAD:   cmd_next.op = reserved ? OP_REJECT : OP_UNLOAD;
                ACT_EXPIRE:   cmd_next.op = OP_EXPIRE;
                ACT_DISPATCH: cmd_next.op = OP_DISPATCH;
                default:      cmd_next.op = OP_DISPATCH;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
        cmd_reg  <= cmd_next;
        addr_reg <= addr_next;
    end

endmodule

`default_nettype wire

// ----- sv/rrq_cmd_fifo.sv -----
// Short command queue between the classifying front and the executing back.
`default_nettype none

module rrq_cmd_fifo
    import rrq_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(FIFO_DEPTH);

    logic [WIDTH-1:0] slots [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slots[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- sv/rrq_back.sv -----
// Executing stage: ready queue memory, task states, context slots and result register.
`default_nettype none

module rrq_back
    import rrq_pkg::*;
#(
    parameter int MAX_TASKS    = 8,
    parameter int ADDRESS_BITS = 21
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cmd_valid,
    output logic                         cmd_pop,
    input  wire cmd_t                    cmd,
    input  wire logic [ADDRESS_BITS-1:0] cmd_addr,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [2:0]                   m_error,
    output logic                         m_head_valid,
    output logic [ID_W-1:0]              m_head_process,
    output logic                         m_fresh_start,
    output logic [OUT_ADDR_W-1:0]        m_resume_address,
    output logic [7:0]                   m_resume_wreg,
    output logic [7:0]                   m_resume_status,
    output logic [7:0]                   m_resume_bank,
    output logic [COUNT_OUT_W-1:0]       m_loaded_count
);

    localparam int PW     = $clog2(MAX_TASKS);
    localparam int CW     = $clog2(MAX_TASKS + 1);
    localparam int CTX_W  = ADDRESS_BITS + REGS_W;
    localparam int COPY_A = (ADDRESS_BITS < OUT_ADDR_W) ? ADDRESS_BITS : OUT_ADDR_W;
    localparam int COPY_C = (CW < COUNT_OUT_W) ? CW : COUNT_OUT_W;
    localparam logic [PW-1:0] LAST_POS = PW'(MAX_TASKS - 1);
    localparam logic [PW:0]   MAX_P    = (PW + 1)'(MAX_TASKS);
    localparam logic [CW-1:0] MAX_C    = CW'(MAX_TASKS);

    // Queue and context storage
    logic [ID_W-1:0]  queue_mem [MAX_TASKS];
    logic [CTX_W-1:0] ctx_mem   [ID_COUNT];
    logic [ID_W-1:0]  q_rd_reg;
    logic [CTX_W-1:0] ctx_rd_reg;
    logic             q_wr_en;
    logic [PW-1:0]    q_wr_addr;
    logic [ID_W-1:0]  q_wr_data;
    logic [PW-1:0]    q_rd_addr;
    logic             ctx_wr_en;

    back_state_t             state_reg;
    back_state_t             state_next;
    cmd_t                    cmd_reg;
    cmd_t                    cmd_next;
    logic [ADDRESS_BITS-1:0] addr_reg;
    logic [ADDRESS_BITS-1:0] addr_next;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic [PW-1:0]           head_ptr_reg;
    logic [PW-1:0]           head_ptr_next;
    logic [ID_W-1:0]         head_id_reg;
    logic [ID_W-1:0]         head_id_next;
    tstate_t                 task_state_reg  [ID_COUNT];
    tstate_t                 task_state_next [ID_COUNT];
    logic [PW-1:0]           pos_reg;
    logic [PW-1:0]           pos_next;
    logic [PW-1:0]           prev_pos_reg;
    logic [PW-1:0]           prev_pos_next;
    logic [CW-1:0]           scan_k_reg;
    logic [CW-1:0]           scan_k_next;
    logic                    found_reg;
    logic                    found_next;
    err_t                    err_reg;
    err_t                    err_next;
    logic                    fresh_reg;
    logic                    fresh_next;
    logic                    use_ctx_reg;
    logic                    use_ctx_next;
    logic                    m_valid_reg;
    logic                    m_valid_next;

    logic [2:0]              out_error_reg;
    logic                    out_head_valid_reg;
    logic [ID_W-1:0]         out_head_process_reg;
    logic                    out_fresh_reg;
    logic [OUT_ADDR_W-1:0]   out_addr_reg;
    logic [REGS_W-1:0]       out_regs_reg;
    logic [COUNT_OUT_W-1:0]  out_count_reg;
    logic [OUT_ADDR_W-1:0]   out_addr_next;
    logic [COUNT_OUT_W-1:0]  out_count_next;
    logic                    load_out;

    logic [PW:0]             tail_sum;
    logic [PW-1:0]           tail_pos;
    logic [PW-1:0]           head_inc;
    logic [PW-1:0]           pos_inc;
    logic [ADDRESS_BITS-1:0] ctx_addr;

    assign tail_sum = (PW + 1)'(head_ptr_reg) + (PW + 1)'(count_reg);
    assign tail_pos = (tail_sum >= MAX_P) ? PW'(tail_sum - MAX_P) : PW'(tail_sum);
    assign head_inc = (head_ptr_reg == LAST_POS) ? '0 : head_ptr_reg + 1'b1;
    assign pos_inc  = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
    assign ctx_addr = ctx_rd_reg[CTX_W-1:REGS_W];

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        addr_next     = addr_reg;
        count_next    = count_reg;
        head_ptr_next = head_ptr_reg;
        head_id_next  = head_id_reg;
        pos_next      = pos_reg;
        prev_pos_next = prev_pos_reg;
        scan_k_next   = scan_k_reg;
        found_next    = found_reg;
        err_next      = err_reg;
        fresh_next    = fresh_reg;
        use_ctx_next  = use_ctx_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        for (int i = 0; i < ID_COUNT; i++) begin
            task_state_next[i] = task_state_reg[i];
        end
        cmd_pop   = 1'b0;
        q_wr_en   = 1'b0;
        q_wr_addr = tail_pos;
        q_wr_data = cmd_reg.id;
        q_rd_addr = head_ptr_reg;
        ctx_wr_en = 1'b0;
        load_out  = 1'b0;

        unique case (state_reg)
            BK_IDLE: begin
                // Start only with the result register free
                if (cmd_valid && !m_valid_reg) begin
                    cmd_pop      = 1'b1;
                    cmd_next     = cmd;
                    addr_next    = cmd_addr;
                    err_next     = ERR_OK;
                    fresh_next   = 1'b0;
                    use_ctx_next = 1'b0;
                    state_next   = BK_EXEC;
                end
            end
            BK_EXEC: begin
                state_next = BK_DONE;
                unique case (cmd_reg.op)
                    OP_REJECT: begin
                        err_next = ERR_RESERVED;
                    end
                    OP_LOAD: begin
                        // A task is queued exactly when its state is not unloaded
                        if (task_state_reg[cmd_reg.id] != TS_UNLOADED) begin
                            err_next = ERR_LOADED;
                        end else if (count_reg == MAX_C) begin
                            err_next = ERR_FULL;
                        end else begin
                            q_wr_en    = 1'b1;
                            q_wr_addr  = tail_pos;
                            q_wr_data  = cmd_reg.id;
                            count_next = count_reg + 1'b1;
                            task_state_next[cmd_reg.id] = TS_FRESH;
                            if (count_reg == '0) begin
                                head_id_next = cmd_reg.id;
                            end
                        end
                    end
                    OP_UNLOAD: begin
                        if (task_state_reg[cmd_reg.id] == TS_UNLOADED) begin
                            err_next = ERR_ABSENT;
                        end else begin
                            task_state_next[cmd_reg.id] = TS_UNLOADED;
                            pos_next    = head_ptr_reg;
                            scan_k_next = '0;
                            found_next  = 1'b0;
                            state_next  = BK_SCAN_RD;
                        end
                    end
                    OP_EXPIRE: begin
                        if (count_reg == '0) begin
                            err_next = ERR_EMPTY;
                        end else begin
                            // Save context, append head at the tail, advance head
                            ctx_wr_en     = 1'b1;
                            q_wr_en       = 1'b1;
                            q_wr_addr     = tail_pos;
                            q_wr_data     = head_id_reg;
                            head_ptr_next = head_inc;
                            state_next    = BK_HEAD_RD;
                        end
                    end
                    OP_DISPATCH: begin
                        if (count_reg == '0) begin
                            err_next = ERR_EMPTY;
                        end else if (task_state_reg[head_id_reg] == TS_RUNNING) begin
                            use_ctx_next = 1'b1;
                        end else begin
                            fresh_next = 1'b1;
                            task_state_next[head_id_reg] = TS_RUNNING;
                        end
                    end
                    default: begin
                        err_next = ERR_RESERVED;
                    end
                endcase
            end
            BK_SCAN_RD: begin
                q_rd_addr  = pos_reg;
                state_next = BK_SCAN_CHK;
            end
            BK_SCAN_CHK: begin
                // Past the match, shift each entry one place toward the head
                if (found_reg) begin
                    q_wr_en   = 1'b1;
                    q_wr_addr = prev_pos_reg;
                    q_wr_data = q_rd_reg;
                end
                found_next    = found_reg || (q_rd_reg == cmd_reg.id);
                prev_pos_next = pos_reg;
                pos_next      = pos_inc;
                scan_k_next   = scan_k_reg + 1'b1;
                if (scan_k_reg + 1'b1 == count_reg) begin
                    count_next = count_reg - 1'b1;
                    state_next = (count_reg == CW'(1)) ? BK_DONE : BK_HEAD_RD;
                end else begin
                    state_next = BK_SCAN_RD;
                end
            end
            BK_HEAD_RD: begin
                q_rd_addr  = head_ptr_reg;
                state_next = BK_HEAD_WAIT;
            end
            BK_HEAD_WAIT: begin
                head_id_next = q_rd_reg;
                state_next   = BK_DONE;
            end
            BK_DONE: begin
                load_out     = 1'b1;
                m_valid_next = 1'b1;
                state_next   = BK_IDLE;
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase

        out_addr_next = '0;
        if (use_ctx_reg) begin
            out_addr_next[COPY_A-1:0] = ctx_addr[COPY_A-1:0];
        end
        out_count_next = '0;
        out_count_next[COPY_C-1:0] = count_reg[COPY_C-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_IDLE;
            count_reg    <= '0;
            head_ptr_reg <= '0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < ID_COUNT; i++) begin
                task_state_reg[i] <= TS_UNLOADED;
            end
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            head_ptr_reg <= head_ptr_next;
            m_valid_reg  <= m_valid_next;
            for (int i = 0; i < ID_COUNT; i++) begin
                task_state_reg[i] <= task_state_next[i];
            end
        end
        cmd_reg      <= cmd_next;
        addr_reg     <= addr_next;
        head_id_reg  <= head_id_next;
        pos_reg      <= pos_next;
        prev_pos_reg <= prev_pos_next;
        scan_k_reg   <= scan_k_next;
        found_reg    <= found_next;
        err_reg      <= err_next;
        fresh_reg    <= fresh_next;
        use_ctx_reg  <= use_ctx_next;
        if (load_out) begin
            out_error_reg        <= err_reg;
            out_head_valid_reg   <= (count_reg != '0);
            out_head_process_reg <= (count_reg != '0) ? head_id_reg : '0;
            out_fresh_reg        <= fresh_reg;
            out_addr_reg         <= out_addr_next;
            out_regs_reg         <= use_ctx_reg ? ctx_rd_reg[REGS_W-1:0] : '0;
            out_count_reg        <= out_count_next;
        end
    end

    // Queue memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (q_wr_en) begin
            queue_mem[q_wr_addr] <= q_wr_data;
        end
        q_rd_reg <= queue_mem[q_rd_addr];
    end

    // Context slots, indexed by task id
    always_ff @(posedge aclk) begin
        if (ctx_wr_en) begin
            ctx_mem[head_id_reg] <= {addr_reg, cmd_reg.regs};
        end
        ctx_rd_reg <= ctx_mem[head_id_reg];
    end

    assign m_valid          = m_valid_reg;
    assign m_error          = out_error_reg;
    assign m_head_valid     = out_head_valid_reg;
    assign m_head_process   = out_head_process_reg;
    assign m_fresh_start    = out_fresh_reg;
    assign m_resume_address = out_addr_reg;
    assign m_resume_wreg    = out_regs_reg[7:0];
    assign m_resume_status  = out_regs_reg[15:8];
    assign m_resume_bank    = out_regs_reg[23:16];
    assign m_loaded_count   = out_count_reg;

endmodule

`default_nettype wire

// ----- verif/round_robin_ready_queue_monitor.sv -----
// Channel monitor for the ready queue: predicts every result and compares it as it arrives.
`timescale 1ns / 1ps

module round_robin_ready_queue_monitor
    import rrq_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic [1:0]             s_action,
    input  logic [ID_W-1:0]        s_process_id,
    input  logic [OUT_ADDR_W-1:0]  s_saved_address,
    input  logic [7:0]             s_saved_wreg,
    input  logic [7:0]             s_saved_status,
    input  logic [7:0]             s_saved_bank,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic [2:0]             m_error,
    input  logic                   m_head_valid,
    input  logic [ID_W-1:0]        m_head_process,
    input  logic                   m_fresh_start,
    input  logic [OUT_ADDR_W-1:0]  m_resume_address,
    input  logic [7:0]             m_resume_wreg,
    input  logic [7:0]             m_resume_status,
    input  logic [7:0]             m_resume_bank,
    input  logic [COUNT_OUT_W-1:0] m_loaded_count,
    output int                     fail_count,
    output int                     pending
);

    typedef struct packed {
        err_t                   error;
        logic                   head_valid;
        logic [ID_W-1:0]        head_process;
        logic                   fresh_start;
        logic [OUT_ADDR_W-1:0]  resume_address;
        logic [7:0]             resume_wreg;
        logic [7:0]             resume_status;
        logic [7:0]             resume_bank;
        logic [COUNT_OUT_W-1:0] loaded_count;
    } sched_result_t;

    // Scheduler image: ready FIFO, run states and saved contexts per task id.
    logic [ID_W-1:0]       ready_ids [ID_COUNT];
    int                    queued;
    tstate_t               run_state [ID_COUNT];
    logic [OUT_ADDR_W-1:0] saved_addr [ID_COUNT];
    logic [REGS_W-1:0]     saved_regs [ID_COUNT];

    sched_result_t awaited_results [$];
    int            mismatches = 0;

    initial begin
        fail_count = 0;
        pending = 0;
    end

    function automatic int find_slot(input logic [ID_W-1:0] pid);
        for (int i = 0; i < queued; i++) begin
            if (ready_ids[i] == pid) return i;
        end
        return -1;
    endfunction

    function automatic sched_result_t schedule_item(input action_t act,
            input logic [ID_W-1:0] pid, input logic [OUT_ADDR_W-1:0] addr,
            input logic [REGS_W-1:0] regs);
        sched_result_t res;
        int pos;
        logic [ID_W-1:0] head;
        res = '0;
        res.error = ERR_OK;
        pos = find_slot(pid);
        head = ready_ids[0];
        case (act)
            ACT_LOAD: begin
                if (pid == 0) res.error = ERR_RESERVED;
                else if (pos >= 0) res.error = ERR_LOADED;
                else if (queued >= ID_COUNT) res.error = ERR_FULL;
                else begin
                    ready_ids[queued] = pid;
                    queued++;
                    run_state[pid] = TS_FRESH;
                end
            end
            ACT_UNLOAD: begin
                if (pid == 0) res.error = ERR_RESERVED;
                else if (pos < 0) res.error = ERR_ABSENT;
                else begin
                    // close the gap behind the removed task
                    for (int i = pos; i + 1 < queued; i++) ready_ids[i] = ready_ids[i + 1];
                    queued--;
                    run_state[pid] = TS_UNLOADED;
                end
            end
            ACT_EXPIRE: begin
                if (queued == 0) res.error = ERR_EMPTY;
                else begin
                    saved_addr[head] = addr;
                    saved_regs[head] = regs;
                    for (int i = 0; i + 1 < queued; i++) ready_ids[i] = ready_ids[i + 1];
                    ready_ids[queued - 1] = head;
                end
            end
            ACT_DISPATCH: begin
                if (queued == 0) res.error = ERR_EMPTY;
                else if (run_state[head] == TS_RUNNING) begin
                    res.resume_address = saved_addr[head];
                    res.resume_wreg    = saved_regs[head][7:0];
                    res.resume_status  = saved_regs[head][15:8];
                    res.resume_bank    = saved_regs[head][23:16];
                end else begin
                    // a task expired before its first run still starts fresh
                    res.fresh_start = 1'b1;
                    run_state[head] = TS_RUNNING;
                end
            end
        endcase
        res.head_valid   = (queued > 0);
        res.head_process = (queued > 0) ? ready_ids[0] : '0;
        res.loaded_count = queued[COUNT_OUT_W-1:0];
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
            input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        sched_result_t want;
        if (!aresetn) begin
            queued = 0;
            for (int i = 0; i < ID_COUNT; i++) run_state[i] = TS_UNLOADED;
            awaited_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unpredicted result, expected none, actual error %0d count %0d",
                             $time, m_error, m_loaded_count);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("error", want.error, m_error);
                    check_field("head_valid", want.head_valid, m_head_valid);
                    check_field("head_process", want.head_process, m_head_process);
                    check_field("fresh_start", want.fresh_start, m_fresh_start);
                    check_field("resume_address", want.resume_address, m_resume_address);
                    check_field("resume_wreg", want.resume_wreg, m_resume_wreg);
                    check_field("resume_status", want.resume_status, m_resume_status);
                    check_field("resume_bank", want.resume_bank, m_resume_bank);
                    check_field("loaded_count", want.loaded_count, m_loaded_count);
                end
            end
            if (s_valid && s_ready) begin
                awaited_results.push_back(schedule_item(action_t'(s_action), s_process_id,
                    s_saved_address, {s_saved_bank, s_saved_status, s_saved_wreg}));
            end
        end
        fail_count <= mismatches;
        pending <= awaited_results.size();
    end

endmodule

// ----- verif/round_robin_ready_queue_test.sv -----
// Top of the ready queue testbench: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module round_robin_ready_queue_test;
    import rrq_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 50;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    action_t                s_action;
    logic [ID_W-1:0]        s_process_id;
    logic [OUT_ADDR_W-1:0]  s_saved_address;
    logic [7:0]             s_saved_wreg;
    logic [7:0]             s_saved_status;
    logic [7:0]             s_saved_bank;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [2:0]             m_error;
    logic                   m_head_valid;
    logic [ID_W-1:0]        m_head_process;
    logic                   m_fresh_start;
    logic [OUT_ADDR_W-1:0]  m_resume_address;
    logic [7:0]             m_resume_wreg;
    logic [7:0]             m_resume_status;
    logic [7:0]             m_resume_bank;
    logic [COUNT_OUT_W-1:0] m_loaded_count;

    int   fail_count;
    int   pending;
    int   quiet_cycles = 0;
    logic calm = 1'b0;

    round_robin_ready_queue dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_process_id     (s_process_id),
        .s_saved_address  (s_saved_address),
        .s_saved_wreg     (s_saved_wreg),
        .s_saved_status   (s_saved_status),
        .s_saved_bank     (s_saved_bank),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_error          (m_error),
        .m_head_valid     (m_head_valid),
        .m_head_process   (m_head_process),
        .m_fresh_start    (m_fresh_start),
        .m_resume_address (m_resume_address),
        .m_resume_wreg    (m_resume_wreg),
        .m_resume_status  (m_resume_status),
        .m_resume_bank    (m_resume_bank),
        .m_loaded_count   (m_loaded_count)
    );

    round_robin_ready_queue_monitor monitor (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_process_id     (s_process_id),
        .s_saved_address  (s_saved_address),
        .s_saved_wreg     (s_saved_wreg),
        .s_saved_status   (s_saved_status),
        .s_saved_bank     (s_saved_bank),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_error          (m_error),
        .m_head_valid     (m_head_valid),
        .m_head_process   (m_head_process),
        .m_fresh_start    (m_fresh_start),
        .m_resume_address (m_resume_address),
        .m_resume_wreg    (m_resume_wreg),
        .m_resume_status  (m_resume_status),
        .m_resume_bank    (m_resume_bank),
        .m_loaded_count   (m_loaded_count),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Stall the result channel with a probability of about 14 percent, never in the calm phase.
    always @(posedge aclk) begin
        if (calm) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(99) >= 14);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Context packed as {address, W, STATUS, BSR}.
    function automatic logic [44:0] rand_ctx();
        logic [63:0] bits;
        bits = {$urandom(), $urandom()};
        return bits[44:0];
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(15) == 0) return '0;
        return ID_W'($urandom_range(ID_COUNT - 1, 1));
    endfunction

    task automatic send_item(input action_t act, input logic [ID_W-1:0] pid,
            input logic [44:0] ctx);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(99) < 14) gap = $urandom_range(3, 1);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= act;
        s_process_id <= pid;
        {s_saved_address, s_saved_wreg, s_saved_status, s_saved_bank} <= ctx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic hold_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        int pick;
        int load_pct;
        int unload_pct;
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_action        <= ACT_LOAD;
        s_process_id    <= '0;
        s_saved_address <= '0;
        s_saved_wreg    <= '0;
        s_saved_status  <= '0;
        s_saved_bank    <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // rejects on an empty scheduler
        send_item(ACT_LOAD, 3'd0, rand_ctx());
        send_item(ACT_UNLOAD, 3'd0, rand_ctx());
        send_item(ACT_EXPIRE, 3'd7, {45{1'b1}});
        send_item(ACT_DISPATCH, 3'd0, rand_ctx());
        send_item(ACT_UNLOAD, 3'd5, rand_ctx());
        for (int id = 1; id < ID_COUNT; id++) send_item(ACT_LOAD, ID_W'(id), rand_ctx());
        send_item(ACT_LOAD, 3'd4, rand_ctx());
        // one full rotation stores a context for every task before any resume
        send_item(ACT_EXPIRE, 3'd0, {45{1'b1}});
        send_item(ACT_EXPIRE, 3'd7, '0);
        for (int n = 0; n < ID_COUNT - 3; n++) begin
            send_item(ACT_EXPIRE, ID_W'($urandom_range(7)), rand_ctx());
        end
        send_item(ACT_DISPATCH, 3'd6, rand_ctx());
        send_item(ACT_DISPATCH, 3'd1, rand_ctx());
        send_item(ACT_UNLOAD, 3'd4, rand_ctx());
        send_item(ACT_UNLOAD, 3'd1, rand_ctx());
        send_item(ACT_DISPATCH, 3'd3, rand_ctx());
        hold_for_results();

        // alternate load-heavy and unload-heavy phases so the queue fills and drains
        for (int ph = 0; ph < 7; ph++) begin
            calm <= (ph == 3);
            load_pct   = (ph % 2 == 0) ? 40 : 20;
            unload_pct = (ph % 2 == 0) ? 15 : 35;
            for (int k = 0; k < 100; k++) begin
                pick = $urandom_range(99);
                if (pick < load_pct) send_item(ACT_LOAD, pick_id(), rand_ctx());
                else if (pick < load_pct + unload_pct) send_item(ACT_UNLOAD, pick_id(), rand_ctx());
                else if ($urandom_range(1) == 0) begin
                    send_item(ACT_EXPIRE, ID_W'($urandom_range(7)), rand_ctx());
                end else begin
                    send_item(ACT_DISPATCH, ID_W'($urandom_range(7)), rand_ctx());
                end
            end
            hold_for_results();
        end

        calm <= 1'b0;
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
